@@ rtl/assert_macros.svh @@
// Assertion macros shared by the console RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define TXT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("console assertion failed");
// Check cons in the cycle after ante.
`define TXT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("console assertion failed");
`else
`define TXT_ASSERT_IMPL(lbl, ante, cons)
`define TXT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/txtcon_pkg.sv @@
// Shared types and constants for the text console.
// No dependencies.
package txtcon_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int COL_PORT_W  = 7;
	localparam int ROW_PORT_W  = 5;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = 16;
	localparam int DELTA_W     = 8;
	// position plus signed offset, wide enough for 127 + 127 and -128
	localparam int SUM_W       = 10;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;

	typedef enum logic [1:0] {
		ACT_PUT  = 2'd0,
		ACT_MOVE = 2'd1,
		ACT_READ = 2'd2
	} action_t;

endpackage

@@ rtl/text_console_with_mouse_cursor_unit.sv @@
// Text console top level: cell store, text cursor and mouse pointer.
// Depends on txtcon_pkg, txtcon_clamp and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one item: action, char_code,
//    move_dx, move_dy, read_col, read_row. Output channel (out_valid/out_ready)
//    returns one item per input: cell_data and both cursor positions.
//  - The cell store is split into an attribute memory and a character memory,
//    each COLUMNS*ROWS entries with one write port and a registered read.
//  - Steps per item, from accept back to ST_IDLE (ST_FINISH loads the result):
//      put character, read cell, unused action : accept, then ST_FINISH
//      mouse move : read old cell at accept; ST_SWAP1 writes it back and reads
//      the new cell; ST_SWAP2 writes it; ST_FINISH. Put character that runs past
//      the last row : ST_BLANK, writing one character entry per cycle, ST_FINISH.
//  - After reset a clearing pass zeroes both memories, one entry per cycle,
//    over all COLUMNS*ROWS entries; in_ready stays low until it ends.
//    Text cursor resets to (0,0), mouse pointer to (COLUMNS/2, ROWS/2).
//  - The result register decouples the two channels: the next item is taken
//    while a result still waits. A stalled receiver holds the following item
//    in its final state until the register frees, then input resumes.
`include "assert_macros.svh"

module text_console_with_mouse_cursor_unit import txtcon_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [CHAR_W-1:0]            char_code,
	input  logic signed [DELTA_W-1:0]    move_dx,
	input  logic signed [DELTA_W-1:0]    move_dy,
	input  logic [COL_PORT_W-1:0]        read_col,
	input  logic [ROW_PORT_W-1:0]        read_row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CELL_W-1:0]            cell_data,
	output logic [COL_PORT_W-1:0]        text_col,
	output logic [ROW_PORT_W-1:0]        text_row,
	output logic [COL_PORT_W-1:0]        mouse_col,
	output logic [ROW_PORT_W-1:0]        mouse_row
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SWAP1  = 6'b000100,
		ST_SWAP2  = 6'b001000,
		ST_BLANK  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	// Linear cell address of a screen position.
	function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		addr_of = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

	// Swap the two nibbles of an attribute byte.
	function automatic logic [ATTR_W-1:0] swap_attr(input logic [ATTR_W-1:0] a);
		swap_attr = {a[3:0], a[7:4]};
	endfunction

	// Control state
	state_t              state_q;
	logic [ADDR_W-1:0]   sweep_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [COL_W-1:0]    ptr_col_q;
	logic [ROW_W-1:0]    ptr_row_q;
	logic                out_valid_q;

	// Per-item payload
	logic [ADDR_W-1:0]   old_addr_q;
	logic                rd_hit_q;
	logic                fwd_q;
	logic [ATTR_W-1:0]   swapped_q;
	logic [CELL_W-1:0]   out_cell_q;
	logic [COL_PORT_W-1:0] out_text_col_q;
	logic [ROW_PORT_W-1:0] out_text_row_q;
	logic [COL_PORT_W-1:0] out_mouse_col_q;
	logic [ROW_PORT_W-1:0] out_mouse_row_q;

	// Cell store: attribute and character halves
	logic [ATTR_W-1:0]   attr_mem [CELLS];
	logic [CHAR_W-1:0]   char_mem [CELLS];
	logic [ATTR_W-1:0]   attr_rd_q;
	logic [CHAR_W-1:0]   char_rd_q;

	logic                attr_we;
	logic [ADDR_W-1:0]   attr_waddr;
	logic [ATTR_W-1:0]   attr_wdata;
	logic                char_we;
	logic [ADDR_W-1:0]   char_waddr;
	logic [CHAR_W-1:0]   char_wdata;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;

	logic                accept;
	logic                fin_load;
	action_t             act;
	logic                is_nl;
	logic                is_print;
	logic [COL_W:0]      col_inc;
	logic [ROW_W:0]      row_inc;
	logic                wrap_col;
	logic                overflow;
	logic                rd_in_range;
	logic [ADDR_W-1:0]   rd_addr_in;
	logic [ADDR_W-1:0]   cur_addr;
	logic [ADDR_W-1:0]   ptr_addr;
	logic [COL_W-1:0]    new_ptr_col;
	logic [ROW_W-1:0]    new_ptr_row;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fin_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign act      = action_t'(action);

	// Put character: cursor advance, row wrap and screen overflow
	assign is_nl    = (char_code == NEWLINE_CODE);
	assign is_print = (char_code != NULL_CODE) && !is_nl;
	assign col_inc  = (COL_W+1)'(cur_col_q) + (COL_W+1)'(1);
	assign row_inc  = (ROW_W+1)'(cur_row_q) + (ROW_W+1)'(1);
	assign wrap_col = is_nl || (col_inc == (COL_W+1)'(COLUMNS));
	assign overflow = wrap_col && (row_inc == (ROW_W+1)'(ROWS));

	// Read cell: range check and address
	assign rd_in_range = (32'(read_col) < 32'(COLUMNS)) && (32'(read_row) < 32'(ROWS));
	assign rd_addr_in  = addr_of(ROW_W'(read_row), COL_W'(read_col));

	assign cur_addr = addr_of(cur_row_q, cur_col_q);
	assign ptr_addr = addr_of(ptr_row_q, ptr_col_q);

	// Pointer move: true signed sum, clamped to the screen
	txtcon_clamp #(
		.LIMIT (COLUMNS),
		.POS_W (COL_W)
	) u_clamp_col (
		.base  (ptr_col_q),
		.delta (move_dx),
		.pos   (new_ptr_col)
	);

	txtcon_clamp #(
		.LIMIT (ROWS),
		.POS_W (ROW_W)
	) u_clamp_row (
		.base  (ptr_row_q),
		.delta (move_dy),
		.pos   (new_ptr_row)
	);

	// Memory port steering per state
	always_comb begin
		attr_we    = 1'b0;
		attr_waddr = sweep_q;
		attr_wdata = '0;
		char_we    = 1'b0;
		char_waddr = sweep_q;
		char_wdata = '0;
		rd_en      = 1'b0;
		rd_addr    = ptr_addr;
		unique case (state_q)
			ST_CLEAR: begin
				// zero both halves, one entry per cycle
				attr_we = 1'b1;
				char_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept) begin
					case (act)
						ACT_PUT: begin
							// cursor is always on screen; the attribute is kept
							char_we    = is_print;
							char_waddr = cur_addr;
							char_wdata = char_code;
						end
						ACT_MOVE: begin
							// fetch attribute under the old pointer
							rd_en   = 1'b1;
							rd_addr = ptr_addr;
						end
						ACT_READ: begin
							rd_en   = rd_in_range;
							rd_addr = rd_addr_in;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SWAP1: begin
				// write back old cell, fetch the new one (pointer already moved)
				attr_we    = 1'b1;
				attr_waddr = old_addr_q;
				attr_wdata = swap_attr(attr_rd_q);
				rd_en      = 1'b1;
				rd_addr    = ptr_addr;
			end
			ST_SWAP2: begin
				// forward the value just written when both positions coincide
				attr_we    = 1'b1;
				attr_waddr = ptr_addr;
				attr_wdata = swap_attr(fwd_q ? swapped_q : attr_rd_q);
			end
			ST_BLANK: begin
				char_we    = 1'b1;
				char_wdata = BLANK_CHAR;
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Cell store memories
	always_ff @(posedge clk) begin
		if (attr_we) begin
			attr_mem[attr_waddr] <= attr_wdata;
		end
		if (rd_en) begin
			attr_rd_q <= attr_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (char_we) begin
			char_mem[char_waddr] <= char_wdata;
		end
		if (rd_en) begin
			char_rd_q <= char_mem[rd_addr];
		end
	end

	// Sequencer and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			ptr_col_q   <= COL_W'(COLUMNS / 2);
			ptr_row_q   <= ROW_W'(ROWS / 2);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FINISH;
						case (act)
							ACT_PUT: begin
								if (char_code != NULL_CODE) begin
									if (overflow) begin
										// home the cursor, then blank the screen
										cur_col_q <= '0;
										cur_row_q <= '0;
										state_q   <= ST_BLANK;
									end else if (wrap_col) begin
										cur_col_q <= '0;
										cur_row_q <= row_inc[ROW_W-1:0];
									end else begin
										cur_col_q <= col_inc[COL_W-1:0];
									end
								end
							end
							ACT_MOVE: begin
								ptr_col_q <= new_ptr_col;
								ptr_row_q <= new_ptr_row;
								state_q   <= ST_SWAP1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SWAP1: begin
					state_q <= ST_SWAP2;
				end
				ST_SWAP2: begin
					state_q <= ST_FINISH;
				end
				ST_BLANK: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-item payload and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_hit_q   <= (act == ACT_READ) && rd_in_range;
			old_addr_q <= ptr_addr;
		end
		if (state_q == ST_SWAP1) begin
			fwd_q     <= (ptr_addr == old_addr_q);
			swapped_q <= swap_attr(attr_rd_q);
		end
		if (fin_load) begin
			out_cell_q      <= rd_hit_q ? {attr_rd_q, char_rd_q} : '0;
			out_text_col_q  <= COL_PORT_W'(cur_col_q);
			out_text_row_q  <= ROW_PORT_W'(cur_row_q);
			out_mouse_col_q <= COL_PORT_W'(ptr_col_q);
			out_mouse_row_q <= ROW_PORT_W'(ptr_row_q);
		end
	end

	assign out_valid = out_valid_q;
	assign cell_data = out_cell_q;
	assign text_col  = out_text_col_q;
	assign text_row  = out_text_row_q;
	assign mouse_col = out_mouse_col_q;
	assign mouse_row = out_mouse_row_q;

	// Checks
	`TXT_ASSERT_IMPL(a_cursor_on_screen, 1'b1, (32'(cur_col_q) < 32'(COLUMNS)) && (32'(cur_row_q) < 32'(ROWS)))
	`TXT_ASSERT_IMPL(a_pointer_on_screen, 1'b1, (32'(ptr_col_q) < 32'(COLUMNS)) && (32'(ptr_row_q) < 32'(ROWS)))
	`TXT_ASSERT_NEXT(a_no_read_zero_cell, fin_load && !rd_hit_q, out_valid && (cell_data == '0))

endmodule

@@ rtl/txtcon_clamp.sv @@
// Signed offset and clamp of one pointer coordinate to [0, LIMIT-1].
// Depends on txtcon_pkg.
module txtcon_clamp import txtcon_pkg::*; #(
	parameter int LIMIT = COLUMNS_DEF,
	parameter int POS_W = $clog2(COLUMNS_DEF)
) (
	input  logic [POS_W-1:0]          base,
	input  logic signed [DELTA_W-1:0] delta,
	output logic [POS_W-1:0]          pos
);

	localparam logic signed [SUM_W-1:0] LIMIT_S = SUM_W'(LIMIT);

	logic signed [SUM_W-1:0] sum;

	assign sum = $signed(SUM_W'(base)) + SUM_W'(delta);

	always_comb begin
		if (sum < $signed(SUM_W'(0))) begin
			pos = '0;
		end else if (sum >= LIMIT_S) begin
			pos = POS_W'(LIMIT - 1);
		end else begin
			pos = sum[POS_W-1:0];
		end
	end

endmodule

@@ dv/text_console_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the text console: watches both channels, keeps its own copy
// of the cell store and both cursors, and compares every result with the prediction.
// Depends on txtcon_pkg for widths, action codes and character codes.
module text_console_checker import txtcon_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                action,
	input  logic [CHAR_W-1:0]         char_code,
	input  logic signed [DELTA_W-1:0] move_dx,
	input  logic signed [DELTA_W-1:0] move_dy,
	input  logic [COL_PORT_W-1:0]     read_col,
	input  logic [ROW_PORT_W-1:0]     read_row,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [CELL_W-1:0]         cell_data,
	input  logic [COL_PORT_W-1:0]     text_col,
	input  logic [ROW_PORT_W-1:0]     text_row,
	input  logic [COL_PORT_W-1:0]     mouse_col,
	input  logic [ROW_PORT_W-1:0]     mouse_row,
	output int                        fail_count,
	output int                        pending,
	output int                        results_checked,
	output int                        screen_clears
);

	localparam int COLS = COLUMNS_DEF;
	localparam int ROWS = ROWS_DEF;

	typedef struct packed {
		logic [CELL_W-1:0]     data;
		logic [COL_PORT_W-1:0] tcol;
		logic [ROW_PORT_W-1:0] trow;
		logic [COL_PORT_W-1:0] mcol;
		logic [ROW_PORT_W-1:0] mrow;
	} console_view_t;

	logic [CELL_W-1:0] screen_cells [COLS*ROWS];
	int text_c;
	int text_r;
	int ptr_c;
	int ptr_r;
	console_view_t awaited_views [$];

	// Mark or unmark the pointer cell: swap the two attribute nibbles.
	function automatic void flip_pointer_attr();
		logic [CELL_W-1:0] v;
		v = screen_cells[ptr_r*COLS + ptr_c];
		screen_cells[ptr_r*COLS + ptr_c] = {v[11:8], v[15:12], v[7:0]};
	endfunction

	function automatic int clamp_axis(int base, logic signed [DELTA_W-1:0] delta, int span);
		int s;
		s = base + delta;
		if (s >= span)
			s = span - 1;
		if (s < 0)
			s = 0;
		return s;
	endfunction

	function automatic console_view_t predict_console_view(logic [1:0] act,
			logic [CHAR_W-1:0] code, logic signed [DELTA_W-1:0] dx,
			logic signed [DELTA_W-1:0] dy, logic [COL_PORT_W-1:0] rc,
			logic [ROW_PORT_W-1:0] rr);
		console_view_t view;
		view = '0;
		case (act)
			ACT_PUT: begin
				if (code != NULL_CODE) begin
					if (code == NEWLINE_CODE) begin
						text_c = 0;
						text_r++;
					end else begin
						screen_cells[text_r*COLS + text_c][CHAR_W-1:0] = code;
						text_c++;
					end
					if (text_c >= COLS) begin
						text_c = 0;
						text_r++;
					end
					// ran off the bottom: blank every character, keep attributes
					if (text_r >= ROWS) begin
						for (int i = 0; i < COLS*ROWS; i++)
							screen_cells[i][CHAR_W-1:0] = BLANK_CHAR;
						text_c = 0;
						text_r = 0;
						screen_clears++;
					end
				end
			end
			ACT_MOVE: begin
				flip_pointer_attr();
				ptr_c = clamp_axis(ptr_c, dx, COLS);
				ptr_r = clamp_axis(ptr_r, dy, ROWS);
				flip_pointer_attr();
			end
			ACT_READ: begin
				if (int'(rc) < COLS && int'(rr) < ROWS)
					view.data = screen_cells[int'(rr)*COLS + int'(rc)];
			end
			default: ;
		endcase
		view.tcol = text_c[COL_PORT_W-1:0];
		view.trow = text_r[ROW_PORT_W-1:0];
		view.mcol = ptr_c[COL_PORT_W-1:0];
		view.mrow = ptr_r[ROW_PORT_W-1:0];
		return view;
	endfunction

	task automatic report(string msg);
		$display("[%0t] checker: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report($sformatf("result %0d: %s is %0h, predicted %0h",
				results_checked, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		console_view_t got;
		console_view_t want;
		if (!arst_n) begin
			foreach (screen_cells[i])
				screen_cells[i] = '0;
			text_c = 0;
			text_r = 0;
			ptr_c = COLS / 2;
			ptr_r = ROWS / 2;
			awaited_views.delete();
			fail_count = 0;
			results_checked = 0;
			screen_clears = 0;
		end else begin
			// drain first: a result always belongs to an earlier item
			if (out_valid && out_ready) begin
				got = {cell_data, text_col, text_row, mouse_col, mouse_row};
				if (awaited_views.size() == 0) begin
					report($sformatf("result %h arrived with nothing awaited", got));
				end else begin
					want = awaited_views.pop_front();
					results_checked++;
					check_field("cell_data", got.data, want.data);
					check_field("text_col", got.tcol, want.tcol);
					check_field("text_row", got.trow, want.trow);
					check_field("mouse_col", got.mcol, want.mcol);
					check_field("mouse_row", got.mrow, want.mrow);
				end
			end
			if (in_valid && in_ready)
				awaited_views.push_back(predict_console_view(action, char_code,
					move_dx, move_dy, read_col, read_row));
		end
		pending = awaited_views.size();
	end

endmodule

@@ dv/tb_text_console_with_mouse_cursor_unit.sv @@
`timescale 1ns / 1ps
// Top of the text console testbench: clock, reset, item stimulus and verdict.
// Depends on txtcon_pkg, text_console_checker and the console RTL.
module tb_text_console_with_mouse_cursor_unit;
	import txtcon_pkg::*;

	// action code the block must treat as a no-op
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam int ITEM_TARGET  = 1250;
	// a screen clear alone sweeps every cell with no item moving, as does
	// the start-up wipe; allow well beyond that before calling it a hang
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 16;
	// points in the random part where the receiver holds off and where
	// the sender pauses for the pipe to empty
	localparam int HOLD_AT      = 400;
	localparam int SETTLE_AT    = 800;

	typedef struct {
		logic [1:0]                act;
		logic [CHAR_W-1:0]         code;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [COL_PORT_W-1:0]     col;
		logic [ROW_PORT_W-1:0]     row;
	} console_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                action = ACT_PUT;
	logic [CHAR_W-1:0]         char_code = '0;
	logic signed [DELTA_W-1:0] move_dx = '0;
	logic signed [DELTA_W-1:0] move_dy = '0;
	logic [COL_PORT_W-1:0]     read_col = '0;
	logic [ROW_PORT_W-1:0]     read_row = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [CELL_W-1:0]         cell_data;
	logic [COL_PORT_W-1:0]     text_col;
	logic [ROW_PORT_W-1:0]     text_row;
	logic [COL_PORT_W-1:0]     mouse_col;
	logic [ROW_PORT_W-1:0]     mouse_row;

	int fail_count;
	int pending;
	int results_checked;
	int screen_clears;

	// item tallies; ignored items (null code, spare action, off-screen
	// read) are kept apart and do not count toward the target
	int effective_items = 0;
	int put_items = 0;
	int move_items = 0;
	int read_items = 0;
	int ignored_items = 0;

	int holds_asked = 0;
	int holds_done = 0;
	bit send_burst = 1'b0;
	bit take_burst = 1'b0;
	int idle_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	text_console_with_mouse_cursor_unit dut (.*);

	text_console_checker checker_i (.*);

	// Fill every field with noise; callers then set the ones that matter,
	// so the unused fields still toggle.
	function automatic console_item_t scrambled_item();
		console_item_t it;
		it.act  = 2'($urandom_range(0, 3));
		it.code = 8'($urandom());
		it.dx   = 8'($urandom());
		it.dy   = 8'($urandom());
		it.col  = 7'($urandom());
		it.row  = 5'($urandom());
		return it;
	endfunction

	// Offer one item after a random gap and hold it until accepted.
	task automatic send_item(console_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action    <= it.act;
		char_code <= it.code;
		move_dx   <= it.dx;
		move_dy   <= it.dy;
		read_col  <= it.col;
		read_row  <= it.row;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		case (it.act)
			ACT_PUT: begin
				if (it.code == NULL_CODE) begin
					ignored_items++;
				end else begin
					put_items++;
					effective_items++;
				end
			end
			ACT_MOVE: begin
				move_items++;
				effective_items++;
			end
			ACT_READ: begin
				if (it.col < COLUMNS_DEF && it.row < ROWS_DEF) begin
					read_items++;
					effective_items++;
				end else begin
					ignored_items++;
				end
			end
			default: ignored_items++;
		endcase
	endtask

	task automatic put_code(logic [CHAR_W-1:0] code);
		console_item_t it;
		it = scrambled_item();
		it.act = ACT_PUT;
		it.code = code;
		send_item(it);
	endtask

	task automatic move_mouse(int dx, int dy);
		console_item_t it;
		it = scrambled_item();
		it.act = ACT_MOVE;
		it.dx = 8'(dx);
		it.dy = 8'(dy);
		send_item(it);
	endtask

	task automatic read_at(int col, int row);
		console_item_t it;
		it = scrambled_item();
		it.act = ACT_READ;
		it.col = 7'(col);
		it.row = 5'(row);
		send_item(it);
	endtask

	// A run of nonzero codes followed by a number of line feeds.
	task automatic type_text(int chars, int line_feeds);
		repeat (chars) put_code(8'($urandom_range(1, 255)));
		repeat (line_feeds) put_code(NEWLINE_CODE);
	endtask

	initial begin : stimulus
		int pick;
		bit settled;
		console_item_t it;
		settled = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The block wipes its store after reset, so the
		// first item simply waits for ready.
		read_at(0, 0);
		read_at(COLUMNS_DEF/2, ROWS_DEF/2);
		read_at(COLUMNS_DEF-1, ROWS_DEF-1);
		put_code(8'h41);
		put_code(8'hFF);
		put_code(8'h01);
		put_code(NULL_CODE);
		put_code(NEWLINE_CODE);
		// clamp at both far corners, then a zero move that swaps twice
		move_mouse(127, 127);
		move_mouse(-128, -128);
		move_mouse(0, 0);
		move_mouse(3, -1);
		// park the pointer on the text cursor and print underneath it
		move_mouse(-3, 1);
		put_code(8'h5A);
		read_at(0, 1);
		move_mouse(0, 0);
		read_at(0, 0);
		// reads off the screen
		read_at(COLUMNS_DEF, 0);
		read_at(0, ROWS_DEF);
		read_at(127, 31);
		it = scrambled_item();
		it.act = ACT_SPARE;
		send_item(it);

		// Random part: mostly lines of text, moves and reads, with long
		// runs that wrap rows, bursts of line feeds that run off the
		// bottom, and a little noise.
		while (effective_items < ITEM_TARGET) begin
			if (holds_asked == 0 && effective_items >= HOLD_AT)
				holds_asked = 1;
			if (!settled && effective_items >= SETTLE_AT) begin
				// drop valid and let every result come home
				settled = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				type_text($urandom_range(1, 12), 1);
			end else if (pick < 41) begin
				type_text($urandom_range(60, 100), 0);
			end else if (pick < 44) begin
				type_text(0, $urandom_range(5, 25));
			end else if (pick < 66) begin
				if ($urandom_range(0, 3) == 0)
					move_mouse($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128);
				else
					move_mouse($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
			end else if (pick < 90) begin
				read_at($urandom_range(0, COLUMNS_DEF-1), $urandom_range(0, ROWS_DEF-1));
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						it = scrambled_item();
						it.act = ACT_SPARE;
						send_item(it);
					end
					1: put_code(NULL_CODE);
					default: read_at($urandom_range(0, 127), $urandom_range(0, 31));
				endcase
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d counted items (%0d put, %0d move, %0d read) and %0d ignored ones.",
			effective_items, put_items, move_items, read_items, ignored_items);
		$display("Checked %0d results; the screen ran off the bottom %0d times.",
			results_checked, screen_clears);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Receiver: random stalls per result, stretches with none, and one long
	// hold-off so the block fills up and drops ready on its input.
	initial begin : result_sink
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_burst = !take_burst;
			stall = take_burst ? 0 : $urandom_range(0, 6);
			if (holds_done < holds_asked) begin
				holds_done++;
				stall = $urandom_range(150, 300);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("No item moved for %0d cycles, %0d results outstanding.",
			STALL_LIMIT, pending);
		$display("FAIL");
		$finish;
	end

endmodule
